FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the three-axis velocity PID block.
// No dependencies; define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under clock and synchronous reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under clock and synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/vpid3_pkg.sv
// Package of the three-axis velocity PID block: sequencer states, register
// indexes, datapath widths and reset values. No dependencies.
package vpid3_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FM,
    ST_MUL_SS,
    ST_MUL_HL,
    ST_MUL_VL,
    ST_ERR,
    ST_MUL_INT,
    ST_INT,
    ST_MUL_GI,
    ST_MUL_GP,
    ST_MUL_GD,
    ST_DIV,
    ST_FORCE,
    ST_DONE
  } state_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HLIM   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_VLIM   = 3'd5;

  localparam logic [15:0] PERIOD_RESET = 16'd1092;
  localparam logic [15:0] GAIN_P_RESET = 16'd256;
  localparam logic [15:0] GAIN_I_RESET = 16'd0;
  localparam logic [15:0] GAIN_D_RESET = 16'd256;
  localparam logic [14:0] HLIM_RESET   = 15'd2560;
  localparam logic [14:0] VLIM_RESET   = 15'd2560;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 96;

  localparam int ACC_W      = 58;
  localparam int DIGIT_W    = 4;
  localparam int MUL_B_W    = 16;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
  localparam int DIV_W      = 50;
  localparam int CNT_W      = 6;
  localparam int ERR_W      = 18;
  localparam int INT_W      = 40;
  localparam int PI_W       = 42;
  localparam int FORCE_W    = 32;

  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

FILE: src/velocity_pid_three_axis_top.sv
// Top level of the three-axis velocity PID controller with trapezoidal integral.
// Depends on vpid3_pkg and on the assertion macros in assert_macros.svh.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   s_tdata: one control tick (commands, axes,
//                                            measured velocity)
//  m_       out        m_tvalid / m_tready   m_tdata: force_x, force_y, force_z
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data: register write
//
// Per axis, a running tick goes through the 50-step restoring divider of the derivative
// term and seven multiplications (eight for y) on the shared 4-bit digit multiplier.
// A paused tick (period zero) goes from acceptance straight to the hand-over state.
// Reset is synchronous and active high; it restores the register defaults and clears
// the integral, the previous errors and the last forces.
// The result sits in an output register, so a stalled sink only delays the hand-over
// of the next result; a new tick is accepted while the previous result waits.

`include "assert_macros.svh"

module velocity_pid_three_axis_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // From bit 0 up: move_forward[13:0], move_side[13:0], move_up[12:0],
  // fwd_dir_x/y/z[13:0], side_dir_x/y/z[13:0], meas_vel_x/y/z[15:0], zero padding.
  input  logic [vpid3_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // From bit 0 up: force_x[31:0], force_y[31:0], force_z[31:0].
  output logic [vpid3_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vpid3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vpid3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AccW   = vpid3_pkg::ACC_W;
  localparam int DigitW = vpid3_pkg::DIGIT_W;
  localparam int MulBW  = vpid3_pkg::MUL_B_W;
  localparam int DivW   = vpid3_pkg::DIV_W;
  localparam int CntW   = vpid3_pkg::CNT_W;
  localparam int ErrW   = vpid3_pkg::ERR_W;
  localparam int IntW   = vpid3_pkg::INT_W;
  localparam int PiW    = vpid3_pkg::PI_W;
  localparam int ForceW = vpid3_pkg::FORCE_W;

  // Configuration registers.
  logic [15:0] period;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [14:0] hlim;
  logic [14:0] vlim;

  // Sequencer.
  vpid3_pkg::state_t state;
  vpid3_pkg::state_t state_next;
  logic [CntW-1:0]   cnt;
  logic [1:0]        axis;
  logic              out_load;
  logic              is_mul;
  logic              mul_last;
  logic              div_last;

  // Latched tick. The per-axis arrays rotate after each axis, so entry 0 always
  // belongs to the axis being worked on.
  logic signed [13:0] mf;
  logic signed [13:0] ms;
  logic        [12:0] mu;
  logic signed [13:0] fd [3];
  logic signed [13:0] sd [3];
  logic signed [15:0] mv [3];

  // Controller state, rotated in the same way.
  logic signed [IntW-1:0]   integral   [3];
  logic signed [ErrW-1:0]   prev_err   [3];
  logic signed [ForceW-1:0] last_force [3];

  // Datapath.
  logic signed [ErrW-1:0]       err;
  logic signed [AccW-1:0]       acc;
  logic signed [AccW-1:0]       mul_a;
  logic        [MulBW-1:0]      mul_b;
  logic signed [AccW-1:0]       op_a;
  logic        [MulBW-1:0]      op_b;
  logic                         op_keep;
  logic signed [AccW+DigitW:0]  part;
  logic signed [AccW-1:0]       acc_sum;
  logic signed [14:0]           mf_w;
  logic signed [14:0]           ms_w;
  logic        [14:0]           mf_mag;
  logic        [14:0]           ms_mag;
  logic signed [ErrW+16:0]      err_raw;
  logic signed [ErrW-1:0]       err_sat;
  logic signed [IntW+1:0]       int_sum;
  logic signed [IntW-1:0]       int_sat;
  logic signed [PiW-1:0]        pi_term;
  logic        [DivW-1:0]       dq;
  logic        [15:0]           dr;
  logic                         dneg;
  logic signed [AccW-1:0]       acc_mag;
  logic        [16:0]           rem_try;
  logic                         q_bit;
  logic signed [DivW:0]         dterm;
  logic signed [PiW+9:0]        f_sum;
  logic signed [ForceW-1:0]     f_sat;

  // ---------------------------------------------------------------------------
  // Sequencer: one state per operation of an axis, counter for digits and steps.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vpid3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign mul_last = (cnt == CntW'(vpid3_pkg::MUL_DIGITS));
  assign div_last = (cnt == CntW'(DivW));

  always_comb begin
    state_next = state;
    s_tready   = (state == vpid3_pkg::ST_IDLE);
    cfg_ready  = (state == vpid3_pkg::ST_IDLE);
    out_load   = (state == vpid3_pkg::ST_DONE) && (!m_tvalid || m_tready);
    is_mul     = 1'b0;
    case (state)
      vpid3_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (period == '0) ? vpid3_pkg::ST_DONE : vpid3_pkg::ST_MUL_FM;
        end
      end
      vpid3_pkg::ST_MUL_FM: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_MUL_SS;
      end
      vpid3_pkg::ST_MUL_SS: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_MUL_HL;
      end
      vpid3_pkg::ST_MUL_HL: begin
        is_mul = 1'b1;
        if (mul_last) begin
          state_next = (axis == vpid3_pkg::AXIS_Y) ? vpid3_pkg::ST_MUL_VL
                                                   : vpid3_pkg::ST_ERR;
        end
      end
      vpid3_pkg::ST_MUL_VL: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_ERR;
      end
      vpid3_pkg::ST_ERR: begin
        state_next = vpid3_pkg::ST_MUL_INT;
      end
      vpid3_pkg::ST_MUL_INT: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_INT;
      end
      vpid3_pkg::ST_INT: begin
        state_next = vpid3_pkg::ST_MUL_GI;
      end
      vpid3_pkg::ST_MUL_GI: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_MUL_GP;
      end
      vpid3_pkg::ST_MUL_GP: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_MUL_GD;
      end
      vpid3_pkg::ST_MUL_GD: begin
        is_mul = 1'b1;
        if (mul_last) state_next = vpid3_pkg::ST_DIV;
      end
      vpid3_pkg::ST_DIV: begin
        if (div_last) state_next = vpid3_pkg::ST_FORCE;
      end
      vpid3_pkg::ST_FORCE: begin
        state_next = (axis == vpid3_pkg::AXIS_Z) ? vpid3_pkg::ST_DONE
                                                 : vpid3_pkg::ST_MUL_FM;
      end
      vpid3_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = vpid3_pkg::ST_IDLE;
      end
      default: begin
        state_next = vpid3_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier. The multiplicand is a signed
  // word; the multiplier is an unsigned 16-bit word consumed four bits a cycle.
  // A signed command is handled by moving its sign onto the multiplicand.
  // ---------------------------------------------------------------------------
  assign mf_w   = 15'(mf);
  assign ms_w   = 15'(ms);
  assign mf_mag = mf_w[14] ? 15'(-mf_w) : 15'(mf_w);
  assign ms_mag = ms_w[14] ? 15'(-ms_w) : 15'(ms_w);

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_keep = 1'b0;
    case (state)
      vpid3_pkg::ST_MUL_FM: begin
        op_a = mf_w[14] ? -AccW'(fd[0]) : AccW'(fd[0]);
        op_b = MulBW'(mf_mag);
      end
      vpid3_pkg::ST_MUL_SS: begin
        op_a    = ms_w[14] ? -AccW'(sd[0]) : AccW'(sd[0]);
        op_b    = MulBW'(ms_mag);
        op_keep = 1'b1;
      end
      vpid3_pkg::ST_MUL_HL: begin
        op_a = acc;
        op_b = MulBW'(hlim);
      end
      vpid3_pkg::ST_MUL_VL: begin
        op_a    = AccW'({mu, 12'b0});
        op_b    = MulBW'(vlim);
        op_keep = 1'b1;
      end
      vpid3_pkg::ST_MUL_INT: begin
        op_a = AccW'(err) + AccW'(prev_err[0]);
        op_b = period;
      end
      vpid3_pkg::ST_MUL_GI: begin
        op_a = AccW'(integral[0]);
        op_b = gain_i;
      end
      vpid3_pkg::ST_MUL_GP: begin
        // The proportional term goes in scaled by 2^16 so that one floor shift
        // serves the sum of it and the integral term.
        op_a    = AccW'(err) <<< 16;
        op_b    = gain_p;
        op_keep = 1'b1;
      end
      vpid3_pkg::ST_MUL_GD: begin
        op_a = (AccW'(err) - AccW'(prev_err[0])) <<< 16;
        op_b = gain_d;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign part    = mul_a * $signed({1'b0, mul_b[DigitW-1:0]});
  assign acc_sum = acc + $signed(part[AccW-1:0]);

  // Error: target in Q8.8 by a floor shift, less the measured velocity, saturated.
  assign err_raw = (ErrW+17)'($signed(acc[AccW-1:24])) - (ErrW+17)'(mv[0]);
  always_comb begin
    if ((err_raw[ErrW+16:ErrW-1] == '0) || (err_raw[ErrW+16:ErrW-1] == '1)) begin
      err_sat = err_raw[ErrW-1:0];
    end else begin
      err_sat = err_raw[ErrW+16] ? {1'b1, {(ErrW-1){1'b0}}} : {1'b0, {(ErrW-1){1'b1}}};
    end
  end

  // Trapezoid step: half of (e + e_prev) * period, floored, then saturated.
  assign int_sum = (IntW+2)'(integral[0]) + (IntW+2)'($signed(acc[IntW+1:1]));
  always_comb begin
    if ((int_sum[IntW+1:IntW-1] == '0) || (int_sum[IntW+1:IntW-1] == '1)) begin
      int_sat = int_sum[IntW-1:0];
    end else begin
      int_sat = int_sum[IntW+1] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end
  end

  // Restoring divider step on the magnitude of the derivative numerator.
  assign acc_mag = acc[AccW-1] ? -acc : acc;
  assign rem_try = {dr, dq[DivW-1]};
  assign q_bit   = (rem_try >= {1'b0, period});

  // Force: the divided derivative term takes back its sign and joins the rest.
  assign dterm = dneg ? -(DivW+1)'(dq) : (DivW+1)'(dq);
  assign f_sum = (PiW+10)'(pi_term) + (PiW+10)'(dterm);
  always_comb begin
    if ((f_sum[PiW+9:ForceW-1] == '0) || (f_sum[PiW+9:ForceW-1] == '1)) begin
      f_sat = f_sum[ForceW-1:0];
    end else begin
      f_sat = f_sum[PiW+9] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers: configuration, counters, controller state, output valid.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      period   <= vpid3_pkg::PERIOD_RESET;
      gain_p   <= vpid3_pkg::GAIN_P_RESET;
      gain_i   <= vpid3_pkg::GAIN_I_RESET;
      gain_d   <= vpid3_pkg::GAIN_D_RESET;
      hlim     <= vpid3_pkg::HLIM_RESET;
      vlim     <= vpid3_pkg::VLIM_RESET;
      cnt      <= '0;
      axis     <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        integral[i]   <= '0;
        prev_err[i]   <= '0;
        last_force[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vpid3_pkg::REG_PERIOD: period <= cfg_data;
          vpid3_pkg::REG_GAIN_P: gain_p <= cfg_data;
          vpid3_pkg::REG_GAIN_I: gain_i <= cfg_data;
          vpid3_pkg::REG_GAIN_D: gain_d <= cfg_data;
          vpid3_pkg::REG_HLIM:   hlim   <= cfg_data[14:0];
          vpid3_pkg::REG_VLIM:   vlim   <= cfg_data[14:0];
          default: begin
          end
        endcase
      end

      cnt <= (state_next != state) ? '0 : cnt + 1'b1;

      if (s_tvalid && s_tready) begin
        axis <= '0;
      end else if (state == vpid3_pkg::ST_FORCE) begin
        axis <= axis + 1'b1;
      end

      if (state == vpid3_pkg::ST_INT) begin
        integral[0] <= int_sat;
      end

      if (state == vpid3_pkg::ST_FORCE) begin
        integral[0]   <= integral[1];
        integral[1]   <= integral[2];
        integral[2]   <= integral[0];
        prev_err[0]   <= prev_err[1];
        prev_err[1]   <= prev_err[2];
        prev_err[2]   <= err;
        last_force[0] <= last_force[1];
        last_force[1] <= last_force[2];
        last_force[2] <= f_sat;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers: latched tick, multiplier, divider and output data.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mf    <= s_tdata[13:0];
      ms    <= s_tdata[27:14];
      mu    <= s_tdata[40:28];
      fd[0] <= s_tdata[54:41];
      fd[1] <= s_tdata[68:55];
      fd[2] <= s_tdata[82:69];
      sd[0] <= s_tdata[96:83];
      sd[1] <= s_tdata[110:97];
      sd[2] <= s_tdata[124:111];
      mv[0] <= s_tdata[140:125];
      mv[1] <= s_tdata[156:141];
      mv[2] <= s_tdata[172:157];
    end else if (state == vpid3_pkg::ST_FORCE) begin
      fd[0] <= fd[1];
      fd[1] <= fd[2];
      fd[2] <= fd[0];
      sd[0] <= sd[1];
      sd[1] <= sd[2];
      sd[2] <= sd[0];
      mv[0] <= mv[1];
      mv[1] <= mv[2];
      mv[2] <= mv[0];
    end

    if (is_mul) begin
      if (cnt == '0) begin
        mul_a <= op_a;
        mul_b <= op_b;
        if (!op_keep) begin
          acc <= '0;
        end
      end else begin
        acc   <= acc_sum;
        mul_a <= mul_a <<< DigitW;
        mul_b <= mul_b >> DigitW;
      end
    end

    if (state == vpid3_pkg::ST_ERR) begin
      err <= err_sat;
    end

    if ((state == vpid3_pkg::ST_MUL_GD) && (cnt == '0)) begin
      pi_term <= acc[AccW-1:16];
    end

    if (state == vpid3_pkg::ST_DIV) begin
      if (cnt == '0) begin
        dq   <= acc_mag[DivW-1:0];
        dneg <= acc[AccW-1];
        dr   <= '0;
      end else begin
        dq <= {dq[DivW-2:0], q_bit};
        dr <= q_bit ? 16'(rem_try - {1'b0, period}) : rem_try[15:0];
      end
    end

    if (out_load) begin
      m_tdata <= {last_force[2], last_force[1], last_force[0]};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_pause_to_done, clk, rst, s_tvalid && s_tready && (period == '0), state == vpid3_pkg::ST_DONE, "paused tick did not go straight to the output")
  `ASSERT_NEXT(a_result_handover, clk, rst, (state == vpid3_pkg::ST_DONE) && (!m_tvalid || m_tready), m_tvalid && (state == vpid3_pkg::ST_IDLE), "finished result was not handed to the output register")
  `ASSERT_IMPL(a_div_rem_bound, clk, rst, (state == vpid3_pkg::ST_DIV) && (cnt != '0), dr < period, "divider remainder not below the period")

endmodule

FILE: tb/tb_velocity_pid_three_axis_top.sv
// Self-checking testbench of the three-axis velocity PID controller top level.
// Depends on vpid3_pkg and on the RTL of velocity_pid_three_axis_top.
module tb_velocity_pid_three_axis_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [vpid3_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [vpid3_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int RANDOM_TICKS = 1650;
  localparam int DRAIN_CYCLES = 300;

  // One control tick laid out exactly as s_tdata: the last member sits in bit 0.
  typedef struct packed {
    logic [2:0]        pad;
    logic [2:0][15:0]  meas_vel;
    logic [2:0][13:0]  side_dir;
    logic [2:0][13:0]  fwd_dir;
    logic [12:0]       move_up;
    logic [13:0]       move_side;
    logic [13:0]       move_forward;
  } tick_t;

  // Forces as carried by m_tdata: element 0 is force_x in the lowest bits.
  typedef logic [2:0][31:0] force_vec_t;

  typedef enum {OP_TICK, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t                           kind;
    tick_t                              tick;
    int                                 gap;
    logic [vpid3_pkg::CFG_INDEX_W-1:0]  idx;
    logic [vpid3_pkg::CFG_DATA_W-1:0]   data;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [vpid3_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [vpid3_pkg::OUT_TDATA_W-1:0]  m_tdata;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [vpid3_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [vpid3_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  velocity_pid_three_axis_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // A 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. The copy of the registers starts at the reset values and is
  // updated on every accepted configuration transaction; the controller state
  // starts cleared, as reset leaves it in the block.
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_period = vpid3_pkg::PERIOD_RESET;
  logic [15:0] cfg_gain_p = vpid3_pkg::GAIN_P_RESET;
  logic [15:0] cfg_gain_i = vpid3_pkg::GAIN_I_RESET;
  logic [15:0] cfg_gain_d = vpid3_pkg::GAIN_D_RESET;
  logic [14:0] cfg_hlim   = vpid3_pkg::HLIM_RESET;
  logic [14:0] cfg_vlim   = vpid3_pkg::VLIM_RESET;

  longint      err_integral [3] = '{0, 0, 0};
  longint      prev_err     [3] = '{0, 0, 0};
  force_vec_t  last_force       = '0;

  force_vec_t  expected_forces [$];
  op_t         pending_ops [$];

  int          failures = 0;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void apply_register(logic [vpid3_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [vpid3_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      vpid3_pkg::REG_PERIOD: cfg_period = data;
      vpid3_pkg::REG_GAIN_P: cfg_gain_p = data;
      vpid3_pkg::REG_GAIN_I: cfg_gain_i = data;
      vpid3_pkg::REG_GAIN_D: cfg_gain_d = data;
      vpid3_pkg::REG_HLIM:   cfg_hlim   = data[14:0];
      vpid3_pkg::REG_VLIM:   cfg_vlim   = data[14:0];
      default: ;
    endcase
  endfunction

  // Works out the forces of one tick and queues them. With the period at zero the
  // controller is paused: the last forces are repeated and nothing is updated.
  function automatic void predict_forces(tick_t t);
    longint mf, ms, mu, per, acc, e, ep, pterm, iterm, dterm, f;
    if (cfg_period != 16'd0) begin
      mf  = longint'($signed(t.move_forward));
      ms  = longint'($signed(t.move_side));
      mu  = longint'(t.move_up);
      per = longint'(cfg_period);
      for (int a = 0; a < 3; a++) begin
        acc = (longint'($signed(t.fwd_dir[a])) * mf +
               longint'($signed(t.side_dir[a])) * ms) * longint'(cfg_hlim);
        if (a == int'(vpid3_pkg::AXIS_Y))
          acc += mu * longint'(cfg_vlim) * 4096;
        // The target is brought down to Q8.8 by a flooring shift.
        e  = clamp_range((acc >>> 24) - longint'($signed(t.meas_vel[a])),
                         -131072, 131071);
        ep = prev_err[a];
        // Trapezoid rule: half the sum of the two errors times the period.
        err_integral[a] = clamp_range(err_integral[a] + (((e + ep) * per) >>> 1),
                                      -64'sd549755813888, 64'sd549755813887);
        pterm = longint'(cfg_gain_p) * e;
        iterm = (longint'(cfg_gain_i) * err_integral[a]) >>> 16;
        dterm = (longint'(cfg_gain_d) * (e - ep) * 65536) / per;
        f = clamp_range(pterm + iterm + dterm, -64'sd2147483648, 64'sd2147483647);
        last_force[a] = f[31:0];
        prev_err[a] = e;
      end
    end
    expected_forces.push_back(last_force);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic tick_t make_tick(int mf, int ms, int mu, int fx, int fy, int fz,
                                      int sx, int sy, int sz, int vx, int vy, int vz);
    tick_t t;
    t = '0;
    t.move_forward = 14'(mf);
    t.move_side    = 14'(ms);
    t.move_up      = 13'(mu);
    t.fwd_dir[0]   = 14'(fx);
    t.fwd_dir[1]   = 14'(fy);
    t.fwd_dir[2]   = 14'(fz);
    t.side_dir[0]  = 14'(sx);
    t.side_dir[1]  = 14'(sy);
    t.side_dir[2]  = 14'(sz);
    t.meas_vel[0]  = 16'(vx);
    t.meas_vel[1]  = 16'(vy);
    t.meas_vel[2]  = 16'(vz);
    return t;
  endfunction

  // Either a tick in the documented ranges (each measured velocity only at random) or raw
  // noise over the full field widths, so that every bit of every field is exercised.
  function automatic tick_t random_tick(bit noise);
    tick_t t;
    t = '0;
    if (noise) begin
      t.move_forward = 14'($urandom);
      t.move_side    = 14'($urandom);
      t.move_up      = 13'($urandom);
      for (int a = 0; a < 3; a++) begin
        t.fwd_dir[a]  = 14'($urandom);
        t.side_dir[a] = 14'($urandom);
        t.meas_vel[a] = 16'($urandom);
      end
    end else begin
      t.move_forward = 14'($urandom_range(0, 8192) - 4096);
      t.move_side    = 14'($urandom_range(0, 8192) - 4096);
      t.move_up      = 13'($urandom_range(0, 4096));
      for (int a = 0; a < 3; a++) begin
        t.fwd_dir[a]  = 14'($urandom_range(0, 8192) - 4096);
        t.side_dir[a] = 14'($urandom_range(0, 8192) - 4096);
        if ($urandom_range(0, 1) == 0)
          t.meas_vel[a] = 16'($urandom_range(0, 4000) - 2000);
        else
          t.meas_vel[a] = 16'($urandom);
      end
    end
    return t;
  endfunction

  // Idle gap in cycles: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 95)
      return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // A register value leaning towards the extremes of its range.
  function automatic logic [15:0] pick_value(int max_value, int reset_value);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'(max_value);
      3: return 16'(reset_value);
      4: return 16'($urandom);
      5: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom_range(0, max_value));
    endcase
  endfunction

  function automatic void push_tick(tick_t t, int gap);
    op_t op;
    op.kind = OP_TICK;
    op.tick = t;
    op.gap  = gap;
    op.idx  = '0;
    op.data = '0;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_cfg(logic [vpid3_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [vpid3_pkg::CFG_DATA_W-1:0] data);
    op_t op;
    op.kind = OP_CFG;
    op.tick = '0;
    op.gap  = 0;
    op.idx  = idx;
    op.data = data;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_drain();
    op_t op;
    op.kind = OP_DRAIN;
    op.tick = '0;
    op.gap  = 0;
    op.idx  = '0;
    op.data = '0;
    pending_ops.push_back(op);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. It works through the queue of pending operations one at a time. A tick
  // is presented on the slave side and held until its transaction completes, at
  // which point the predictor is run on it. A register write is only presented once
  // every expected result has been received, so the block is idle when it lands;
  // a drain operation simply holds the sender back until that point. Valid signals
  // are worked out first and assigned once per edge, so a valid that stays high
  // for the next operation is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  tick_t held_tick = '0;
  int    gap_left  = 0;

  always @(posedge clk) begin : driver
    logic next_sv, next_cv;
    op_t  op;
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      next_sv = s_tvalid;
      next_cv = cfg_valid;
      if (s_tvalid && s_tready) begin
        predict_forces(held_tick);
        next_sv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        next_cv = 1'b0;
      end
      if (!next_sv && !next_cv) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_TICK: begin
              void'(pending_ops.pop_front());
              s_tdata   <= op.tick;
              held_tick <= op.tick;
              gap_left  <= op.gap;
              next_sv = 1'b1;
            end
            OP_CFG: begin
              if (expected_forces.size() == 0) begin
                void'(pending_ops.pop_front());
                cfg_index <= op.idx;
                cfg_data  <= op.data;
                next_cv = 1'b1;
              end
            end
            default: begin
              if (expected_forces.size() == 0)
                void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      s_tvalid  <= next_sv;
      cfg_valid <= next_cv;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each completed master-side transaction is compared, axis by axis,
  // with the oldest expected set of forces. The ready line is stalled at random,
  // with short and long stalls and calm stretches in which it stays high.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int calm_left  = 0;

  always @(posedge clk) begin : monitor
    force_vec_t got, want;
    logic       next_ready;
    int         r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_forces.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual x=%0d y=%0d z=%0d",
                   $time, $signed(got[0]), $signed(got[1]), $signed(got[2]));
        end else begin
          want = expected_forces.pop_front();
          for (int a = 0; a < 3; a++) begin
            if (got[a] !== want[a]) begin
              failures++;
              $display("%0t: force axis %0d mismatch, expected %0d, actual %0d",
                       $time, a, $signed(want[a]), $signed(got[a]));
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        next_ready = 1'b0;
      end else if (calm_left > 0) begin
        calm_left <= calm_left - 1;
        next_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 999);
        next_ready = 1'b1;
        if (r < 5) begin
          calm_left <= $urandom_range(200, 800);
        end else if (r < 300) begin
          stall_left <= $urandom_range(0, 5);
          next_ready = 1'b0;
        end else if (r < 310) begin
          stall_left <= $urandom_range(20, 300);
          next_ready = 1'b0;
        end
      end
      m_tready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a directed part over the extremes and the special cases, then
  // random phases, each under its own register setting.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int    queued;
    int    len;
    int    style;
    int    drain_at;
    bit    steady;
    tick_t t;

    // Directed part under the reset register values.
    push_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    push_tick(make_tick(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                        0, 0, 0), 0);
    push_tick(make_tick(-4096, -4096, 0, -4096, -4096, -4096, -4096, -4096, -4096,
                        32767, 32767, 32767), 0);
    push_tick(make_tick(4096, -4096, 4096, 4096, -4096, 4096, -4096, 4096, -4096,
                        -32768, -32768, -32768), 0);
    // Sideways command only, then upward command only.
    push_tick(make_tick(0, 4096, 0, 0, 0, 0, 4096, 0, -4096, 0, 0, 0), 0);
    push_tick(make_tick(0, 0, 4096, 0, 0, 0, 0, 0, 0, 100, -100, 0), 0);
    // Edge codes of commands and directions: all ones, then the most negative and most positive codes.
    push_tick(make_tick(-1, -1, 8191, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0);
    push_tick(make_tick(-8192, 8191, 4097, -8192, 8191, -8192, 8191, -8192, 8191,
                        0, -1, 21845), 0);

    // Paused controller: the last forces must be repeated.
    push_cfg(vpid3_pkg::REG_PERIOD, 16'd0);
    push_tick(make_tick(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                        -32768, 32767, 0), 0);
    push_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);

    // Shortest period and full gains, so the error and the force saturate. The horizontal
    // limit is written with its unused top bit set, and the undecoded indexes are written
    // too.
    push_cfg(vpid3_pkg::REG_PERIOD, 16'd1);
    push_cfg(vpid3_pkg::REG_GAIN_P, 16'hFFFF);
    push_cfg(vpid3_pkg::REG_GAIN_I, 16'hFFFF);
    push_cfg(vpid3_pkg::REG_GAIN_D, 16'hFFFF);
    push_cfg(vpid3_pkg::REG_HLIM, 16'hFFFF);
    push_cfg(vpid3_pkg::REG_VLIM, 16'h7FFF);
    push_cfg(REG_SPARE_A, 16'h0000);
    push_cfg(REG_SPARE_B, 16'hFFFF);
    push_tick(make_tick(-8192, -8192, 8191, -8192, -8192, -8192, -8192, -8192, -8192,
                        -32768, -32768, -32768), 0);
    push_tick(make_tick(-8192, 8191, 0, 8191, 8191, 8191, 8191, 8191, 8191,
                        32767, 32767, 32767), 0);
    push_tick(make_tick(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                        -32768, -32768, -32768), 0);
    push_tick(make_tick(-4096, -4096, 0, 4096, 4096, 4096, 4096, 4096, 4096,
                        32767, 32767, 32767), 0);

    // Longest period with the gains off.
    push_cfg(vpid3_pkg::REG_PERIOD, 16'hFFFF);
    push_cfg(vpid3_pkg::REG_GAIN_P, 16'd0);
    push_cfg(vpid3_pkg::REG_GAIN_I, 16'd0);
    push_cfg(vpid3_pkg::REG_GAIN_D, 16'd0);
    push_tick(make_tick(4096, 0, 4096, 4096, 0, 0, 0, 0, 4096, 1, -1, 0), 0);
    push_tick(make_tick(0, -4096, 0, 0, 4096, 0, 0, 0, -4096, -2, 2, 0), 0);

    // Random phases. Each phase rewrites every register, then runs a stretch of
    // in-range ticks, of one tick repeated (which walks the integral up to its
    // bound when the gains and period allow), or of noise. Once per phase the sender
    // waits until every outstanding result has come back.
    queued = 0;
    while (queued < RANDOM_TICKS) begin
      if ($urandom_range(0, 9) == 0)
        push_cfg(vpid3_pkg::REG_PERIOD, 16'd0);
      else
        push_cfg(vpid3_pkg::REG_PERIOD, ($urandom_range(0, 3) == 0) ? 16'd1092 :
                                        (pick_value(65535, 1092) | 16'd1));
      push_cfg(vpid3_pkg::REG_GAIN_P, pick_value(65535, 256));
      push_cfg(vpid3_pkg::REG_GAIN_I, pick_value(65535, 0));
      push_cfg(vpid3_pkg::REG_GAIN_D, pick_value(65535, 256));
      push_cfg(vpid3_pkg::REG_HLIM, pick_value(32767, 2560));
      push_cfg(vpid3_pkg::REG_VLIM, pick_value(32767, 2560));
      if ($urandom_range(0, 4) == 0)
        push_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));

      len      = $urandom_range(30, 100);
      style    = $urandom_range(0, 9);
      steady   = ($urandom_range(0, 3) == 0);
      drain_at = $urandom_range(0, len - 1);
      t        = random_tick(style == 9);
      for (int k = 0; k < len; k++) begin
        if (k == drain_at)
          push_drain();
        if (style < 6)
          t = random_tick(1'b0);
        else if (style == 9)
          t = random_tick(1'b1);
        push_tick(t, steady ? 0 : pick_gap());
      end
      queued += len;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait until everything has been sent and answered, then leave a margin in
    // which any stray result would still be caught.
    while (pending_ops.size() != 0 || expected_forces.size() != 0 || s_tvalid || cfg_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && expected_forces.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #(80_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
